>>> rtl/core/fss_pkg.sv
// Shared constants and types for the first substring match block.
package fss_pkg;

    // Default sizes, handed to the top level parameters
    localparam int     MAX_TERM_DEF = 16;
    localparam longint MAX_TEXT_DEF = 64'd65536;

    // Fixed field widths
    localparam int BYTE_W  = 8;
    localparam int PIDX_W  = 4;
    localparam int CFG_W   = 5;
    localparam int OFS_W   = 16;

    // Request kinds carried on s_tuser
    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_TEXT = 1'b1;

    // Per-cycle control broadcast to every window cell
    typedef struct packed {
        logic shift;   // take the neighbor's byte
        logic clear;   // drop the window at end of text
    } cell_ctrl_t;

endpackage

>>> rtl/core/fss_pattern.sv
// Pattern byte store: one register per pattern position, written by load requests.
module fss_pattern #(
    parameter int MAX_TERM = fss_pkg::MAX_TERM_DEF
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [fss_pkg::PIDX_W-1:0]                wr_index,
    input  logic [fss_pkg::BYTE_W-1:0]                wr_byte,
    output logic [MAX_TERM-1:0][fss_pkg::BYTE_W-1:0]  pattern
);

    logic [MAX_TERM-1:0][fss_pkg::BYTE_W-1:0] store_reg;

    // Write the addressed entry; indexes past the store are dropped
    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_TERM; k++) begin
            if (wr_en && (32'(wr_index) == k)) begin
                store_reg[k] <= wr_byte;
            end
        end
    end

    assign pattern = store_reg;

endmodule

>>> rtl/core/fss_cell.sv
// One window cell: holds one text byte, passes it on, and checks its input byte against its pattern byte.
module fss_cell #(
    parameter int MAX_TERM = fss_pkg::MAX_TERM_DEF,
    parameter int IDX      = 0,
    localparam int LEN_W   = $clog2(MAX_TERM + 1),
    localparam int IDX_W   = $clog2(MAX_TERM)
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  fss_pkg::cell_ctrl_t                       ctrl,
    input  logic [fss_pkg::BYTE_W-1:0]                byte_in,
    input  logic [MAX_TERM-1:0][fss_pkg::BYTE_W-1:0]  pattern,
    input  logic [LEN_W-1:0]                          len,
    output logic [fss_pkg::BYTE_W-1:0]                byte_out,
    output logic                                      match_ok
);

    logic [fss_pkg::BYTE_W-1:0] win_reg;
    logic [fss_pkg::BYTE_W-1:0] win_next;
    logic                       active;
    logic [LEN_W-1:0]           diff;
    logic [IDX_W-1:0]           sel;

    // Cell IDX of the window lines up with pattern byte len-1-IDX
    assign active   = (LEN_W'(IDX) < len);
    assign diff     = len - LEN_W'(IDX + 1);
    assign sel      = diff[IDX_W-1:0];
    assign match_ok = !active || (byte_in == pattern[sel]);

    // Advance the window, or drop it at end of text
    always_comb begin
        win_next = win_reg;
        if (ctrl.clear) begin
            win_next = '0;
        end else if (ctrl.shift) begin
            win_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else begin
            win_reg <= win_next;
        end
    end

    assign byte_out = win_reg;

endmodule

>>> rtl/core/first_substring_match.sv
// Top level of the first substring match block: window cell chain, counters, result register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  s_       | s_tvalid / s_tready        | tuser: action; tdata: byte, index; tlast
//  m_       | m_tvalid / m_tready        | tuser: found, overflow; tdata: match offset
//  cfg_     | cfg_wr_en (no wait)        | cfg_wr_data: pattern length
//
// One request per cycle while s_tready is high: each text byte shifts through the cell chain
// and all cells compare in parallel in the accepting cycle; the result is captured in the output register.
// Reset is synchronous on aresetn low and clears window, counters and the output valid flag.
// A stalled result blocks new requests only while m_tready stays low; taking the result
// frees the slot in the same cycle.
module first_substring_match #(
    parameter int     MAX_TERM = fss_pkg::MAX_TERM_DEF,
    parameter longint MAX_TEXT = fss_pkg::MAX_TEXT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // cfg
    input  logic                         cfg_wr_en,
    input  logic [fss_pkg::CFG_W-1:0]    cfg_wr_data,   // [4:0] pattern_length
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,       // [7:0] byte_value, [11:8] pattern_index
    input  logic                         s_tuser,       // [0] action
    input  logic                         s_tlast,       // last_of_text
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,       // [15:0] match_offset
    output logic [1:0]                   m_tuser        // [0] found, [1] offset_overflow
);

    localparam int LEN_W = $clog2(MAX_TERM + 1);
    localparam int CNT_W = $clog2(MAX_TEXT + 2);

    logic [fss_pkg::CFG_W-1:0]                 len_cfg_reg;
    logic [LEN_W-1:0]                          len_eff;
    logic [MAX_TERM-1:0][fss_pkg::BYTE_W-1:0]  pattern;
    logic [MAX_TERM:0][fss_pkg::BYTE_W-1:0]    chain;
    logic [MAX_TERM-1:0]                       match_ok;
    fss_pkg::cell_ctrl_t                       ctrl;

    logic [CNT_W-1:0] seen_reg;
    logic [CNT_W-1:0] seen_next;
    logic             reported_reg;
    logic             reported_next;

    logic             in_acc;
    logic             is_text;
    logic             is_load;
    logic             hit;
    logic             result;
    logic             over;
    logic             sat;
    logic [CNT_W-1:0] start;

    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic                     found_reg;
    logic                     ovf_reg;
    logic [fss_pkg::OFS_W-1:0] offset_reg;

    // Hold the pattern length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg <= fss_pkg::CFG_W'(1);
        end else if (cfg_wr_en) begin
            len_cfg_reg <= cfg_wr_data;
        end
    end

    // Clamp the length to 1..MAX_TERM
    always_comb begin
        if (len_cfg_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(len_cfg_reg) > MAX_TERM) begin
            len_eff = LEN_W'(MAX_TERM);
        end else begin
            len_eff = LEN_W'(len_cfg_reg);
        end
    end

    // Request decode
    assign s_tready = !m_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign is_text  = in_acc && (s_tuser == fss_pkg::ACTION_TEXT);
    assign is_load  = in_acc && (s_tuser == fss_pkg::ACTION_LOAD);

    fss_pattern #(
        .MAX_TERM (MAX_TERM)
    ) u_pattern (
        .aclk     (aclk),
        .wr_en    (is_load),
        .wr_index (s_tdata[11:8]),
        .wr_byte  (s_tdata[7:0]),
        .pattern  (pattern)
    );

    // Window chain: the newest byte enters cell 0
    assign ctrl.shift = is_text;
    assign ctrl.clear = is_text && s_tlast;
    assign chain[0]   = s_tdata[7:0];

    for (genvar j = 0; j < MAX_TERM; j++) begin : g_cell
        fss_cell #(
            .MAX_TERM (MAX_TERM),
            .IDX      (j)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .byte_in  (chain[j]),
            .pattern  (pattern),
            .len      (len_eff),
            .byte_out (chain[j+1]),
            .match_ok (match_ok[j])
        );
    end

    // Count text bytes, saturating one past MAX_TEXT
    assign seen_next = (seen_reg <= CNT_W'(MAX_TEXT)) ? seen_reg + CNT_W'(1) : seen_reg;

    // Match decision and offset
    assign hit    = !reported_reg && (seen_next >= CNT_W'(len_eff)) && (&match_ok);
    assign start  = seen_next - CNT_W'(len_eff);
    assign over   = seen_next > CNT_W'(MAX_TEXT);
    assign sat    = over || (64'(start) > 64'hFFFF);
    assign result = is_text && (hit || (s_tlast && !reported_reg));

    assign reported_next = s_tlast ? 1'b0 : (hit ? 1'b1 : reported_reg);

    // Hold per-text counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end else if (is_text) begin
            seen_reg     <= s_tlast ? '0 : seen_next;
            reported_reg <= reported_next;
        end
    end

    // Output register: load on a result, drop once taken
    assign m_valid_next = result ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result) begin
            found_reg <= hit;
            if (hit) begin
                offset_reg <= sat ? 16'hFFFF : fss_pkg::OFS_W'(start);
                ovf_reg    <= sat;
            end else begin
                offset_reg <= '0;
                ovf_reg    <= over;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = offset_reg;
    assign m_tuser  = {ovf_reg, found_reg};

endmodule

>>> tb/sv/first_substring_match_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for first_substring_match: directed and random searches.
module first_substring_match_test;

    localparam int     TERM_N    = fss_pkg::MAX_TERM_DEF;
    localparam longint TEXT_N    = fss_pkg::MAX_TEXT_DEF;
    localparam int     DRAIN_CYC = 4;
    localparam int     PHASE_N   = 6;
    localparam int     PHASE_REQ = 100;

    typedef struct packed {
        logic       action;
        logic [7:0] value;
        logic [3:0] pidx;
        logic       last;
    } search_req_t;

    typedef struct packed {
        logic        found;
        logic [15:0] offset;
        logic        overflow;
    } search_res_t;

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic [fss_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic                      s_tvalid    = 1'b0;
    wire                       s_tready;
    logic [15:0]               s_tdata     = '0;
    logic                      s_tuser     = 1'b0;
    logic                      s_tlast     = 1'b0;
    wire                       m_tvalid;
    logic                      m_tready    = 1'b0;
    wire  [15:0]               m_tdata;
    wire  [1:0]                m_tuser;

    // Predictor state: pattern, window, counters, length register
    logic [7:0]                pat_mem [TERM_N];
    logic [7:0]                window  [TERM_N];
    longint                    seen_cnt;
    logic                      reported;
    logic [fss_pkg::CFG_W-1:0] len_reg = 5'd1;

    // Pattern as the generator sees it, in request order
    logic [7:0]       gen_pat [TERM_N];

    search_req_t      request_q[$];
    search_res_t      awaited_results[$];
    search_req_t      live_req;
    search_res_t      head_res;
    logic [7:0]       text_buf[$];
    int               mismatch_count = 0;
    logic             idle_on = 1'b1;

    first_substring_match i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // [7:0] byte_value, [11:8] pattern_index
        .s_tuser     (s_tuser),      // [0] action
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),      // [15:0] match_offset
        .m_tuser     (m_tuser)       // [0] found, [1] offset_overflow
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #200_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int eff_len(input logic [fss_pkg::CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > TERM_N)
            return TERM_N;
        return int'(v);
    endfunction

    task automatic clear_text();
        foreach (window[i])
            window[i] = 8'h00;
        seen_cnt = 0;
        reported = 1'b0;
    endtask

    // Advance the search by one accepted request and queue the result it gives
    task automatic step_search(input search_req_t r);
        int     len;
        longint start;
        logic   hit;
        logic   over;
        if (r.action == fss_pkg::ACTION_LOAD) begin
            if (r.pidx < TERM_N)
                pat_mem[r.pidx] = r.value;
            return;
        end
        for (int i = TERM_N - 1; i > 0; i--)
            window[i] = window[i - 1];
        window[0] = r.value;
        if (seen_cnt <= TEXT_N)
            seen_cnt++;
        len  = eff_len(len_reg);
        over = seen_cnt > TEXT_N;
        hit  = !reported && seen_cnt >= len;
        for (int k = 0; k < len && hit; k++)
            if (window[len - 1 - k] != pat_mem[k])
                hit = 1'b0;
        if (hit) begin
            start = seen_cnt - len;
            if (over || start > 16'hFFFF) begin
                over  = 1'b1;
                start = 16'hFFFF;
            end
            awaited_results.push_back('{found: 1'b1, offset: start[15:0], overflow: over});
            reported = 1'b1;
        end else if (r.last && !reported) begin
            awaited_results.push_back('{found: 1'b0, offset: 16'h0000, overflow: over});
        end
        if (r.last)
            clear_text();
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Driver: hold a request until taken, then present the next one or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                step_search(live_req);
            if (!s_tvalid || s_tready) begin
                if (request_q.size() > 0 && (!idle_on || $urandom_range(99) >= 10)) begin
                    live_req = request_q.pop_front();
                    s_tdata  <= {4'b0000, live_req.pidx, live_req.value};
                    s_tuser  <= live_req.action;
                    s_tlast  <= live_req.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result against the oldest awaited one
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unawaited result tdata=%h tuser=%b",
                                              m_tdata, m_tuser));
                end else begin
                    head_res = awaited_results.pop_front();
                    if (m_tuser[0] !== head_res.found)
                        report_mismatch($sformatf("found %b, want %b",
                                                  m_tuser[0], head_res.found));
                    if (m_tdata !== head_res.offset)
                        report_mismatch($sformatf("offset %0d, want %0d",
                                                  m_tdata, head_res.offset));
                    if (m_tuser[1] !== head_res.overflow)
                        report_mismatch($sformatf("overflow %b, want %b",
                                                  m_tuser[1], head_res.overflow));
                end
            end
            m_tready <= !idle_on || $urandom_range(99) >= 10;
        end
    end

    task automatic push_req(input logic action, input logic [7:0] value,
                            input logic [3:0] pidx, input logic last);
        request_q.push_back('{action: action, value: value, pidx: pidx, last: last});
        if (action == fss_pkg::ACTION_LOAD)
            gen_pat[pidx] = value;
    endtask

    // Queue text_buf as one text, with an optional load before byte ld_at
    task automatic push_text_seq(input int ld_at, input logic [3:0] ld_idx,
                                 input logic [7:0] ld_val);
        foreach (text_buf[i]) begin
            if (i == ld_at)
                push_req(fss_pkg::ACTION_LOAD, ld_val, ld_idx, 1'($urandom_range(1)));
            push_req(fss_pkg::ACTION_TEXT, text_buf[i], 4'($urandom_range(15)),
                     i == text_buf.size() - 1);
        end
    endtask

    function automatic logic [7:0] filler_byte(input int len);
        if ($urandom_range(1))
            return gen_pat[$urandom_range(len - 1)];
        return 8'($urandom_range(255));
    endfunction

    // Build one random text: mostly the pattern embedded, some broken, some noise, some with a load
    task automatic push_text_run(input int mode);
        int len;
        int pre;
        int post;
        int cut;
        len  = eff_len(len_reg);
        pre  = $urandom_range(8);
        post = $urandom_range(4);
        text_buf.delete();
        repeat (pre) text_buf.push_back(filler_byte(len));
        if (mode < 8) begin
            for (int k = 0; k < len; k++)
                text_buf.push_back(gen_pat[k]);
            if (mode >= 6) begin
                cut = text_buf.size() - 1 - $urandom_range(len - 1);
                text_buf[cut] = text_buf[cut] ^ (8'h01 << $urandom_range(7));
            end
        end
        repeat (post) text_buf.push_back(filler_byte(len));
        if (text_buf.size() == 0)
            text_buf.push_back(filler_byte(len));
        push_text_seq((mode == 9) ? $urandom_range(text_buf.size() - 1) : -1,
                      4'($urandom_range(TERM_N - 1)), 8'($urandom_range(255)));
    endtask

    // Wait until every request is taken and every result is in, then let the pipe settle
    task automatic wait_idle();
        while (request_q.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_length(input logic [fss_pkg::CFG_W-1:0] v);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        len_reg = v;
    endtask

    // Stimulus sequence
    initial begin
        int         plan [PHASE_N];
        int         count;
        int         q_was;
        logic       narrow;
        logic [7:0] sym_a;
        logic [7:0] sym_b;

        plan = '{16, 0, 31, 2, 1, 3};
        plan[PHASE_N - 1] = $urandom_range(3, 15);
        clear_text();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: short text, match on final byte, repeated match, mid-text load
        write_length(5'd3);
        push_req(fss_pkg::ACTION_LOAD, 8'h00, 4'd0, 1'b0);
        push_req(fss_pkg::ACTION_LOAD, 8'hFF, 4'd1, 1'b0);
        push_req(fss_pkg::ACTION_LOAD, 8'h5A, 4'd2, 1'b0);
        push_req(fss_pkg::ACTION_LOAD, 8'hA5, 4'd15, 1'b1);
        text_buf = {8'h00, 8'hFF};
        push_text_seq(-1, 4'd0, 8'h00);
        text_buf = {8'h00, 8'hFF, 8'h5A};
        push_text_seq(-1, 4'd0, 8'h00);
        text_buf = {8'h11, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'hFF, 8'h5A, 8'h22};
        push_text_seq(-1, 4'd0, 8'h00);
        text_buf = {8'h00, 8'hFF, 8'h77};
        push_text_seq(2, 4'd2, 8'h77);

        // Random phases, one pattern length each; one phase runs without idling
        for (int p = 0; p < PHASE_N; p++) begin
            write_length(fss_pkg::CFG_W'(plan[p]));
            idle_on = (p != 2);
            narrow  = 1'($urandom_range(1));
            sym_a   = 8'($urandom_range(255));
            sym_b   = 8'($urandom_range(255));
            for (int i = 0; i < TERM_N; i++)
                push_req(fss_pkg::ACTION_LOAD,
                         narrow ? ($urandom_range(1) ? sym_a : sym_b)
                                : 8'($urandom_range(255)),
                         4'(i), $urandom_range(9) == 0);
            count = 0;
            while (count < PHASE_REQ) begin
                q_was = request_q.size();
                push_text_run($urandom_range(9));
                count += request_q.size() - q_was;
            end
        end
        idle_on = 1'b1;
        wait_idle();

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> first_substring_match.f
rtl/core/fss_pkg.sv
rtl/core/fss_pattern.sv
rtl/core/fss_cell.sv
rtl/core/first_substring_match.sv
tb/sv/first_substring_match_test.sv
